// File: rtl/segment_closest_point_defines.svh
// assertion macros for the segment closest point block
// no dependencies
`ifndef SEGMENT_CLOSEST_POINT_DEFINES_SVH
`define SEGMENT_CLOSEST_POINT_DEFINES_SVH
// implication checked at every clock edge outside reset
`define SCP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
// next-cycle implication outside reset
`define SCP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`endif

// File: rtl/scp_pkg.sv
// types and constants for the segment closest point block
// no dependencies
`timescale 1ns / 1ps
package scp_pkg;
  localparam int CoordW = 32;
  localparam int CoordFrac = 16;
  localparam int TFrac = 16;
  localparam int TW = 17;
  localparam int DistW = 48;
  localparam int DiffW = 33;
  localparam int ProdW = 66;
  localparam int SumW = 68;
  localparam int DivStages = TFrac;

  localparam logic [2:0] REG_START_X = 3'd0;
  localparam logic [2:0] REG_START_Y = 3'd1;
  localparam logic [2:0] REG_START_Z = 3'd2;
  localparam logic [2:0] REG_END_X = 3'd3;
  localparam logic [2:0] REG_END_Y = 3'd4;
  localparam logic [2:0] REG_END_Z = 3'd5;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
  } scp_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] near_x;
    logic signed [CoordW-1:0] near_y;
    logic signed [CoordW-1:0] near_z;
    logic [TW-1:0]            t_param;
    logic [DistW-1:0]         dist_sq;
    logic                     degenerate;
  } scp_out_t;
endpackage

// File: rtl/segment_closest_point.sv
// segment closest point: top level, deep pipeline with restoring divider
// depends on scp_pkg and segment_closest_point_defines.svh
// usage:
//   configuration: cfg_we/cfg_index/cfg_data write start (0..2) and end (3..5)
//   points; write only while the block is idle, other indexes are ignored.
//   input: in_valid/in_stall carry one query point per request.
//   output: out_valid/out_stall carry near point, t, squared distance, flag.
//   throughput: one request per cycle while not stalled, set by the fully
//   pipelined datapath: one divider stage per fractional t bit, split multiply stages before and after.
//   pipeline from accepted request to output valid: 4 setup stages,
//   16 divider stages, 5 output stages.
//   a stall from the receiver freezes the whole pipeline; in_stall is raised
//   only while the last stage holds a result that is not taken, so no
//   request is lost or repeated.
//   reset clears all valid bits and the six segment registers to zero.
`timescale 1ns / 1ps
`include "segment_closest_point_defines.svh"
module segment_closest_point
  import scp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [CoordW-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  scp_in_t           in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output scp_out_t          out_data
);
  localparam int NS = 4 + DivStages + 5;

  // segment registers
  logic signed [CoordW-1:0] seg_r [6];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) seg_r[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_X: seg_r[0] <= cfg_data;
        REG_START_Y: seg_r[1] <= cfg_data;
        REG_START_Z: seg_r[2] <= cfg_data;
        REG_END_X:   seg_r[3] <= cfg_data;
        REG_END_Y:   seg_r[4] <= cfg_data;
        REG_END_Z:   seg_r[5] <= cfg_data;
        default: ;
      endcase
    end
  end

  // global advance: whole pipe moves unless output is held
  logic adv;
  logic [NS-1:0] vld_r;
  assign adv = !(vld_r[NS-1] && out_stall);
  assign in_stall = !adv;
  assign out_valid = vld_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NS-2:0], in_valid};
    end
  end

  // stage 1: differences
  logic signed [DiffW-1:0] d1_r [3], w1_r [3];
  logic signed [CoordW-1:0] p1_r [3];
  logic signed [CoordW-1:0] pin [3];
  assign pin[0] = in_data.point_x;
  assign pin[1] = in_data.point_y;
  assign pin[2] = in_data.point_z;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d1_r[i] <= DiffW'(seg_r[i+3]) - DiffW'(seg_r[i]);
        w1_r[i] <= DiffW'(pin[i]) - DiffW'(seg_r[i]);
        p1_r[i] <= pin[i];
      end
    end
  end

  // stage 2: products (33x33 signed), one multiplier stage
  logic signed [ProdW-1:0] dd2_r [3], wd2_r [3];
  logic signed [CoordW-1:0] p2_r [3];
  logic signed [DiffW-1:0] d2_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dd2_r[i] <= ProdW'(d1_r[i]) * ProdW'(d1_r[i]);
        wd2_r[i] <= ProdW'(w1_r[i]) * ProdW'(d1_r[i]);
        p2_r[i] <= p1_r[i];
        d2_r[i] <= d1_r[i];
      end
    end
  end

  // stage 3: sums
  logic [SumW-1:0] l3_r;
  logic signed [SumW-1:0] q3_r;
  logic signed [CoordW-1:0] p3_r [3];
  logic signed [DiffW-1:0] d3_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      l3_r <= SumW'(dd2_r[0]) + SumW'(dd2_r[1]) + SumW'(dd2_r[2]);
      q3_r <= SumW'(wd2_r[0]) + SumW'(wd2_r[1]) + SumW'(wd2_r[2]);
      p3_r <= p2_r;
      d3_r <= d2_r;
    end
  end

  // stage 4: classify projection
  typedef struct packed {
    logic [SumW-1:0] rem;
    logic [SumW-1:0] lsq;
    logic [TW-1:0]   t;
    logic            degen;
  } div_t;
  div_t dv_r [DivStages+1];
  logic signed [CoordW-1:0] pd_r [DivStages+1][3];
  logic signed [DiffW-1:0] dd_r [DivStages+1][3];
  always_ff @(posedge clk) begin
    if (adv) begin
      dv_r[0].lsq <= l3_r;
      dv_r[0].degen <= (l3_r == '0);
      if (l3_r == '0 || q3_r[SumW-1] || q3_r == '0) begin
        dv_r[0].rem <= '0;
        dv_r[0].t <= '0;
      end else if (q3_r >= $signed(l3_r)) begin
        dv_r[0].rem <= '0;
        dv_r[0].t <= TW'(1) << TFrac;
      end else begin
        dv_r[0].rem <= q3_r;
        dv_r[0].t <= '0;
      end
      pd_r[0] <= p3_r;
      dd_r[0] <= d3_r;
    end
  end

  // divider stages: one quotient bit each
  for (genvar g = 0; g < DivStages; g++) begin : g_div
    logic [SumW-1:0] sh;
    assign sh = dv_r[g].rem << 1;
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[g+1].lsq <= dv_r[g].lsq;
        dv_r[g+1].degen <= dv_r[g].degen;
        if (dv_r[g].t[TFrac]) begin
          dv_r[g+1].rem <= '0;
          dv_r[g+1].t <= dv_r[g].t;
        end else if (sh >= dv_r[g].lsq && !dv_r[g].degen) begin
          dv_r[g+1].rem <= sh - dv_r[g].lsq;
          dv_r[g+1].t <= TW'({dv_r[g].t[TW-2:0], 1'b1});
        end else begin
          dv_r[g+1].rem <= dv_r[g].degen ? '0 : sh;
          dv_r[g+1].t <= TW'({dv_r[g].t[TW-2:0], 1'b0});
        end
        pd_r[g+1] <= pd_r[g];
        dd_r[g+1] <= dd_r[g];
      end
    end
  end

  // output stage a: t * d
  localparam int TDW = TW + 1 + DiffW;
  logic signed [TDW-1:0] td5_r [3];
  logic signed [CoordW-1:0] p5_r [3], s5_r [3];
  logic [TW-1:0] t5_r;
  logic dg5_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        td5_r[i] <= $signed({1'b0, dv_r[DivStages].t}) * TDW'(dd_r[DivStages][i]);
        s5_r[i] <= seg_r[i];
      end
      p5_r <= pd_r[DivStages];
      t5_r <= dv_r[DivStages].t;
      dg5_r <= dv_r[DivStages].degen;
    end
  end

  // output stage b: near point (arithmetic shift floors) and error
  logic signed [CoordW-1:0] n6_r [3];
  logic signed [DiffW-1:0] e6_r [3];
  logic [TW-1:0] t6_r;
  logic dg6_r;
  logic signed [CoordW-1:0] nr [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nr[i] = s5_r[i] + CoordW'(td5_r[i] >>> TFrac);
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        n6_r[i] <= nr[i];
        e6_r[i] <= DiffW'(p5_r[i]) - DiffW'(nr[i]);
      end
      t6_r <= t5_r;
      dg6_r <= dg5_r;
    end
  end

  // output stage c: squares
  logic [ProdW-1:0] sq7_r [3];
  logic signed [CoordW-1:0] n7_r [3];
  logic [TW-1:0] t7_r;
  logic dg7_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq7_r[i] <= ProdW'(ProdW'(e6_r[i]) * ProdW'(e6_r[i]));
      end
      n7_r <= n6_r;
      t7_r <= t6_r;
      dg7_r <= dg6_r;
    end
  end

  // output stage d: sum
  logic [SumW-1:0] ds8_r;
  logic signed [CoordW-1:0] n8_r [3];
  logic [TW-1:0] t8_r;
  logic dg8_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      ds8_r <= SumW'(sq7_r[0]) + SumW'(sq7_r[1]) + SumW'(sq7_r[2]);
      n8_r <= n7_r;
      t8_r <= t7_r;
      dg8_r <= dg7_r;
    end
  end

  // output stage e: scale, saturate, result register
  localparam int HiW = SumW - CoordFrac - DistW;
  scp_out_t out_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.near_x <= n8_r[0];
      out_r.near_y <= n8_r[1];
      out_r.near_z <= n8_r[2];
      out_r.t_param <= t8_r;
      out_r.degenerate <= dg8_r;
      if (ds8_r[SumW-1 -: HiW] != '0) out_r.dist_sq <= '1;
      else out_r.dist_sq <= ds8_r[CoordFrac +: DistW];
    end
  end
  assign out_data = out_r;

  // checks
  `SCP_ASSERT_IMPL(a_stall_hold, out_valid && out_stall, in_stall)
  `SCP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `SCP_ASSERT_IMPL(a_t_range, out_valid, out_data.t_param <= (TW'(1) << TFrac))
  `SCP_ASSERT_IMPL(a_degen_t, out_valid && out_data.degenerate, out_data.t_param == '0)
endmodule
